// ===== sv/hlcd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the header/length/checksum deframer: frame constants and result codes.
// Has no dependencies. The interfaces and the top level use it.
package hlcd_pkg;

    localparam int unsigned BUF_DEPTH_DEFAULT = 32;

    localparam logic [7:0] HDR_FIRST  = 8'h68;
    localparam logic [7:0] HDR_SECOND = 8'h50;
    localparam logic [7:0] END_MARK   = 8'h16;
    localparam logic [8:0] BODY_COUNT = 9'd14;
    localparam logic [4:0] CHECK_POS  = 5'd15;
    localparam logic [8:0] LEN_AT     = 9'd2;
    localparam logic [4:0] FIRST_BODY_IDX = 5'd2;
    localparam logic [4:0] SECOND_HDR_IDX = 5'd1;
    localparam logic [7:0] HDR_SUM    = HDR_FIRST + HDR_SECOND;

    typedef enum logic [2:0] {
        ST_NONE    = 3'd0,
        ST_STORED  = 3'd1,
        ST_OK      = 3'd2,
        ST_CK_ERR  = 3'd3,
        ST_NO_END  = 3'd4
    } status_t;

endpackage

// ===== sv/hlcd_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channels of the deframer: received bytes in, per-byte results out.
// Depends on hlcd_pkg for the result code type.
interface hlcd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hlcd_result_if;
    logic              valid;
    logic              ready;
    hlcd_pkg::status_t status;
    logic              store_enable;
    logic [4:0]        store_index;
    logic              in_frame;

    modport source (output valid, output status, output store_enable,
                    output store_index, output in_frame, input ready);
    modport sink   (input valid, input status, input store_enable,
                    input store_index, input in_frame, output ready);
endinterface

// ===== sv/header_length_checksum_deframer_unit.sv =====
`timescale 1ns / 1ps
// Top level of the header/length/checksum deframer.
// Depends on hlcd_pkg and on the channel interfaces in hlcd_if.sv.
//
// Usage:
//   rx carries one received byte per transfer; res returns exactly one result
//   per byte: status code, store enable and index for the frame buffer, and
//   whether the receiver is inside a frame after that byte.
//   cfg_we/cfg_wdata write the enable bit; write it only while no byte is in
//   flight. With enable clear, bytes pass through with status none and no
//   state change.
// Latency and throughput:
//   A byte updates the deframer state in the cycle it transfers, and its
//   result appears from the result register on the next cycle. One byte per
//   cycle is sustained while res is ready; the only limit is the single result register.
// Reset:
//   rst_n clears enable, the frame state, the write pointer, the checksum and
//   the held previous byte, and empties the result register.
// Stall:
//   While res is stalled the result holds; rx is ready while the result
//   register is empty or will be emptied in the same cycle.
module header_length_checksum_deframer_unit #(
    parameter int unsigned BUF_DEPTH = hlcd_pkg::BUF_DEPTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    hlcd_byte_if.sink            rx,
    hlcd_result_if.source        res
);

    localparam logic [5:0] DEPTH_LIMIT = 6'(BUF_DEPTH);

    logic       enable_reg;
    logic [7:0] prev_byte_reg,   prev_byte_next;
    logic       frame_active_reg, frame_active_next;
    logic [8:0] remaining_reg,   remaining_next;
    logic [4:0] write_ptr_reg,   write_ptr_next;
    logic [7:0] running_sum_reg, running_sum_next;

    logic              out_valid_reg;
    hlcd_pkg::status_t status_reg,   status_next;
    logic              store_en_reg, store_en_next;
    logic [4:0]        store_idx_reg, store_idx_next;
    logic              in_frame_reg;

    logic       take;
    logic [4:0] wp_base;
    logic [4:0] wp_inc;
    logic [8:0] rem_dec;

    assign rx.ready = !out_valid_reg || res.ready;
    assign take     = rx.valid && rx.ready;

    assign wp_base = ({1'b0, write_ptr_reg} >= DEPTH_LIMIT) ? 5'd0 : write_ptr_reg;
    assign wp_inc  = wp_base + 5'd1;
    assign rem_dec = remaining_reg - 9'd1;

    always_comb
    begin
        prev_byte_next    = prev_byte_reg;
        frame_active_next = frame_active_reg;
        remaining_next    = remaining_reg;
        write_ptr_next    = write_ptr_reg;
        running_sum_next  = running_sum_reg;
        status_next       = hlcd_pkg::ST_NONE;
        store_en_next     = 1'b0;
        store_idx_next    = 5'd0;

        if (enable_reg)
        begin
            write_ptr_next = wp_base;
            if (!frame_active_reg)
            begin
                // hunt for the header pair
                if (prev_byte_reg == hlcd_pkg::HDR_FIRST && rx.rx_byte == hlcd_pkg::HDR_SECOND)
                begin
                    frame_active_next = 1'b1;
                    remaining_next    = hlcd_pkg::BODY_COUNT;
                    running_sum_next  = hlcd_pkg::HDR_SUM;
                    write_ptr_next    = hlcd_pkg::FIRST_BODY_IDX;
                    status_next       = hlcd_pkg::ST_STORED;
                    store_en_next     = 1'b1;
                    store_idx_next    = hlcd_pkg::SECOND_HDR_IDX;
                end
                prev_byte_next = rx.rx_byte;
            end
            else
            begin
                store_en_next  = 1'b1;
                store_idx_next = wp_base;
                write_ptr_next = wp_inc;
                remaining_next = rem_dec;
                if (rem_dec == 9'd0)
                begin
                    frame_active_next = 1'b0;
                    status_next       = (rx.rx_byte == hlcd_pkg::END_MARK) ?
                                        hlcd_pkg::ST_OK : hlcd_pkg::ST_NO_END;
                    prev_byte_next    = rx.rx_byte;
                end
                else
                begin
                    // length byte extends the frame
                    if (rem_dec == hlcd_pkg::LEN_AT)
                        remaining_next = rem_dec + {1'b0, rx.rx_byte};
                    if (wp_inc == hlcd_pkg::CHECK_POS && rx.rx_byte != running_sum_reg)
                    begin
                        // abort; keep the previous byte
                        frame_active_next = 1'b0;
                        write_ptr_next    = 5'd0;
                        status_next       = hlcd_pkg::ST_CK_ERR;
                    end
                    else
                    begin
                        running_sum_next = running_sum_reg + rx.rx_byte;
                        status_next      = hlcd_pkg::ST_STORED;
                        prev_byte_next   = rx.rx_byte;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg       <= 1'b0;
            prev_byte_reg    <= 8'd0;
            frame_active_reg <= 1'b0;
            remaining_reg    <= 9'd0;
            write_ptr_reg    <= 5'd0;
            running_sum_reg  <= 8'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                enable_reg <= cfg_wdata;
            if (take)
            begin
                prev_byte_reg    <= prev_byte_next;
                frame_active_reg <= frame_active_next;
                remaining_reg    <= remaining_next;
                write_ptr_reg    <= write_ptr_next;
                running_sum_reg  <= running_sum_next;
                out_valid_reg    <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload: load on transfer, hold otherwise
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            status_reg    <= status_next;
            store_en_reg  <= store_en_next;
            store_idx_reg <= store_idx_next;
            in_frame_reg  <= frame_active_next;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.status       = status_reg;
    assign res.store_enable = store_en_reg;
    assign res.store_index  = store_idx_reg;
    assign res.in_frame     = in_frame_reg;

`ifndef SYNTHESIS
    a_idx_zero_when_no_store: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.store_enable |-> res.store_index == 5'd0)
        else $error("store index set without store enable");

    a_store_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> ((res.status == hlcd_pkg::ST_NONE) == !res.store_enable))
        else $error("store enable disagrees with status");

    a_frame_end_leaves_frame: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.status == hlcd_pkg::ST_OK || res.status == hlcd_pkg::ST_CK_ERR
                      || res.status == hlcd_pkg::ST_NO_END) |-> !res.in_frame)
        else $error("frame end reported while still in frame");

    a_header_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(frame_active_reg) |-> remaining_reg == hlcd_pkg::BODY_COUNT
                                 && write_ptr_reg == hlcd_pkg::FIRST_BODY_IDX
                                 && running_sum_reg == hlcd_pkg::HDR_SUM)
        else $error("frame start did not load counters");
`endif

endmodule

// ===== dv/header_length_checksum_deframer_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for header_length_checksum_deframer_unit: drives byte traffic
// with random gaps and stalls and checks every per-byte result against a local model.
// Depends on hlcd_pkg and the channel interfaces in hlcd_if.sv.
module header_length_checksum_deframer_unit_test;

    localparam int BUF_DEPTH     = 32;
    localparam int RANDOM_ITEMS  = 700;
    localparam int PHASE_ITEMS   = 250;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        hlcd_pkg::status_t status;
        logic              store_enable;
        logic [4:0]        store_index;
        logic              in_frame;
    } deframe_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    hlcd_byte_if   rx_if ();
    hlcd_result_if res_if ();

    header_length_checksum_deframer_unit #(
        .BUF_DEPTH(BUF_DEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .rx       (rx_if),
        .res      (res_if)
    );

    always #1 clk = ~clk;

    // Deframer state as the block should hold it
    logic       dfr_enable;
    logic [7:0] dfr_prev   = 8'h00;
    logic       dfr_active = 1'b0;
    logic [8:0] dfr_left   = 9'd0;
    logic [4:0] dfr_wptr   = 5'd0;
    logic [7:0] dfr_sum    = 8'h00;

    deframe_result_t expected_results[$];
    int              errors          = 0;
    int              quiet_cycles    = 0;
    int              sink_hold       = 0;
    bit              steady_flow;
    int              bytes_enabled;
    int              bytes_setup;
    int              results_checked = 0;
    int              status_count[5] = '{default: 0};

    function automatic deframe_result_t deframe_byte(input logic [7:0] value);
        deframe_result_t r;
        r = '{status: hlcd_pkg::ST_NONE, store_enable: 1'b0, store_index: 5'd0,
              in_frame: 1'b0};
        if (dfr_enable)
        begin
            if (int'(dfr_wptr) >= BUF_DEPTH)
                dfr_wptr = 5'd0;
            if (!dfr_active)
            begin
                if (dfr_prev == hlcd_pkg::HDR_FIRST && value == hlcd_pkg::HDR_SECOND)
                begin
                    dfr_active     = 1'b1;
                    dfr_left       = hlcd_pkg::BODY_COUNT;
                    dfr_sum        = hlcd_pkg::HDR_FIRST + hlcd_pkg::HDR_SECOND;
                    dfr_wptr       = hlcd_pkg::FIRST_BODY_IDX;
                    r.status       = hlcd_pkg::ST_STORED;
                    r.store_enable = 1'b1;
                    r.store_index  = hlcd_pkg::SECOND_HDR_IDX;
                end
                dfr_prev = value;
            end
            else
            begin
                r.store_enable = 1'b1;
                r.store_index  = dfr_wptr;
                dfr_wptr       = dfr_wptr + 5'd1;
                dfr_left       = dfr_left - 9'd1;
                if (dfr_left == 9'd0)
                begin
                    dfr_active = 1'b0;
                    r.status   = (value == hlcd_pkg::END_MARK) ?
                                 hlcd_pkg::ST_OK : hlcd_pkg::ST_NO_END;
                    dfr_prev   = value;
                end
                else
                begin
                    if (dfr_left == hlcd_pkg::LEN_AT)
                        dfr_left = dfr_left + {1'b0, value};
                    // abort keeps the previous byte
                    if (dfr_wptr == hlcd_pkg::CHECK_POS && value != dfr_sum)
                    begin
                        dfr_active = 1'b0;
                        dfr_wptr   = 5'd0;
                        r.status   = hlcd_pkg::ST_CK_ERR;
                    end
                    else
                    begin
                        dfr_sum  = dfr_sum + value;
                        r.status = hlcd_pkg::ST_STORED;
                        dfr_prev = value;
                    end
                end
            end
        end
        r.in_frame = dfr_active;
        return r;
    endfunction

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Predict on every input transfer, check on every result transfer
    always @(posedge clk)
    begin : check_results
        deframe_result_t seen;
        deframe_result_t want;
        bit              moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (rx_if.valid && rx_if.ready)
            begin
                expected_results.push_back(deframe_byte(rx_if.rx_byte));
                moved = 1'b1;
            end
            if (res_if.valid && res_if.ready)
            begin
                moved              = 1'b1;
                seen.status        = res_if.status;
                seen.store_enable  = res_if.store_enable;
                seen.store_index   = res_if.store_index;
                seen.in_frame      = res_if.in_frame;
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with nothing expected: status %0d", seen.status);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    results_checked++;
                    status_count[int'(want.status)]++;
                    if (seen.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, seen.status);
                        errors++;
                    end
                    if (seen.store_enable !== want.store_enable)
                    begin
                        $error("store_enable: expected %0d, got %0d",
                               want.store_enable, seen.store_enable);
                        errors++;
                    end
                    if (seen.store_index !== want.store_index)
                    begin
                        $error("store_index: expected %0d, got %0d",
                               want.store_index, seen.store_index);
                        errors++;
                    end
                    if (seen.in_frame !== want.in_frame)
                    begin
                        $error("in_frame: expected %0d, got %0d", want.in_frame, seen.in_frame);
                        errors++;
                    end
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Result side back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            res_if.ready <= 1'b0;
        else if (sink_hold > 0)
        begin
            res_if.ready <= 1'b0;
            sink_hold    <= sink_hold - 1;
        end
        else
        begin
            res_if.ready <= 1'b1;
            if (!steady_flow && $urandom_range(0, 99) < 20)
                sink_hold <= idle_gap();
        end
    end

    task automatic send_byte(input logic [7:0] value);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= value;
        if (dfr_enable)
            bytes_enabled++;
        else
            bytes_setup++;
        do
            @(posedge clk);
        while (!rx_if.ready);
    endtask

    // Drop valid and hold until every result is back and the block settles
    task automatic wait_idle();
        rx_if.valid <= 1'b0;
        // let the checker record the last transfer first
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_enable(input logic value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        dfr_enable = value;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Build a frame the way the block counts it: length bytes extend the
    // remaining count, the byte stored at index 14 carries the running sum.
    task automatic send_frame(input int len, input bit bad_sum, input bit bad_end,
                              input bit with_header, input bit extreme_fill);
        logic [8:0] left;
        logic [7:0] sum;
        logic [4:0] idx;
        logic [7:0] value;
        bit         first_len;
        if (with_header)
        begin
            send_byte(hlcd_pkg::HDR_FIRST);
            send_byte(hlcd_pkg::HDR_SECOND);
        end
        left      = hlcd_pkg::BODY_COUNT;
        sum       = hlcd_pkg::HDR_SUM;
        idx       = hlcd_pkg::FIRST_BODY_IDX;
        first_len = 1'b1;
        forever
        begin
            left = left - 9'd1;
            if (left == 9'd0)
            begin
                value = hlcd_pkg::END_MARK;
                if (bad_end)
                begin
                    value = 8'($urandom_range(0, 255));
                    if (value == hlcd_pkg::END_MARK)
                        value = ~hlcd_pkg::END_MARK;
                end
                send_byte(value);
                break;
            end
            if (idx + 5'd1 == hlcd_pkg::CHECK_POS)
                value = bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum;
            else if (left == hlcd_pkg::LEN_AT)
                value = first_len ? 8'(len)
                      : ($urandom_range(0, 3) == 0 ? 8'($urandom_range(1, 6)) : 8'h00);
            else if (extreme_fill)
                value = idx[0] ? 8'hFF : 8'h00;
            else
                value = 8'($urandom_range(0, 255));
            if (left == hlcd_pkg::LEN_AT)
            begin
                left      = left + {1'b0, value};
                first_len = 1'b0;
            end
            send_byte(value);
            if (bad_sum && idx + 5'd1 == hlcd_pkg::CHECK_POS)
                break;
            sum = sum + value;
            idx = idx + 5'd1;
        end
    endtask

    task automatic test_setup_mode();
        send_byte(hlcd_pkg::HDR_FIRST);
        send_byte(hlcd_pkg::HDR_SECOND);
        send_byte(8'h00);
        send_byte(8'hFF);
        wait_idle();
        write_enable(1'b0);
        write_enable(1'b1);
        // previous byte is still the reset value, so no header here
        send_byte(hlcd_pkg::HDR_SECOND);
        wait_idle();
    endtask

    task automatic test_good_frame();
        send_frame(0, 1'b0, 1'b0, 1'b1, 1'b1);
        wait_idle();
    endtask

    task automatic test_checksum_abort();
        // length byte 0x68 survives the abort and pairs with the next 0x50
        send_frame(int'(hlcd_pkg::HDR_FIRST), 1'b1, 1'b0, 1'b1, 1'b0);
        send_byte(hlcd_pkg::HDR_SECOND);
        send_frame(0, 1'b0, 1'b0, 1'b0, 1'b0);
        wait_idle();
    endtask

    task automatic test_missing_end();
        send_frame(3, 1'b0, 1'b1, 1'b1, 1'b0);
        send_frame(255, 1'b0, 1'b0, 1'b1, 1'b0);
        wait_idle();
    endtask

    task automatic test_setup_mode_in_frame();
        send_byte(hlcd_pkg::HDR_FIRST);
        send_byte(hlcd_pkg::HDR_SECOND);
        repeat (4) send_byte(8'($urandom_range(0, 255)));
        wait_idle();
        write_enable(1'b0);
        repeat (4) send_byte(8'($urandom_range(0, 255)));
        wait_idle();
        write_enable(1'b1);
        repeat (12) send_byte(hlcd_pkg::END_MARK);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int start_count;
        int phase;
        int pick;
        int len;
        start_count = bytes_enabled;
        phase       = 0;
        while (bytes_enabled - start_count < RANDOM_ITEMS)
        begin
            if (bytes_enabled - start_count >= (phase + 1) * PHASE_ITEMS)
            begin
                phase++;
                wait_idle();
                write_enable(1'b0);
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
                wait_idle();
                write_enable(1'b1);
                steady_flow = (phase % 3 == 1);
            end
            pick = $urandom_range(0, 99);
            if (pick < 70)
                len = $urandom_range(0, 6);
            else if (pick < 93)
                len = $urandom_range(7, 40);
            else if (pick < 98)
                len = $urandom_range(41, 120);
            else
                len = $urandom_range(200, 255);
            pick = $urandom_range(0, 99);
            if (pick < 65)
                send_frame(len, 1'b0, 1'b0, 1'b1, 1'b0);
            else if (pick < 75)
                send_frame(len, 1'b1, 1'b0, 1'b1, 1'b0);
            else if (pick < 85)
                send_frame(len, 1'b0, 1'b1, 1'b1, 1'b0);
            else
            begin
                // broken headers and line noise
                if ($urandom_range(0, 2) == 0)
                    send_byte(hlcd_pkg::HDR_FIRST);
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            end
        end
        steady_flow = 1'b0;
        wait_idle();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = 1'b0;
        rx_if.valid    = 1'b0;
        rx_if.rx_byte  = 8'h00;
        dfr_enable     = 1'b0;
        steady_flow    = 1'b0;
        bytes_enabled  = 0;
        bytes_setup    = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_setup_mode();
        test_good_frame();
        test_checksum_abort();
        test_missing_end();
        test_setup_mode_in_frame();
        test_random_traffic();

        $display("Checked %0d results: %0d bytes enabled, %0d in set-up mode",
                 results_checked, bytes_enabled, bytes_setup);
        $display("Frames ok %0d, checksum aborts %0d, missing end marks %0d, stored %0d",
                 status_count[int'(hlcd_pkg::ST_OK)], status_count[int'(hlcd_pkg::ST_CK_ERR)],
                 status_count[int'(hlcd_pkg::ST_NO_END)],
                 status_count[int'(hlcd_pkg::ST_STORED)]);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
